### rtl/core/msd_pkg.sv
package msd_pkg;

	localparam int MAX_SAMPLES_DEF = 1024;
	localparam int SAMPLE_W        = 16;
	localparam int COUNT_OUT_W     = 11;
	localparam int DEV_W           = SAMPLE_W + 1;
	localparam int SQ_W            = 2 * DEV_W;
	localparam int VAR_W           = 34;
	localparam int ROOT_W          = VAR_W / 2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SINGLE   = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

endpackage

### rtl/core/sample_mean_and_std_deviation_core.sv
// sample mean and sample standard deviation, two passes over a sample store
//
// input: an item is taken when start is high and busy is low. a beat with
// has_sample writes sample_value (signed q4.12) into the store; one beat per
// cycle while collecting, busy stays low. samples beyond MAX_SAMPLES are
// dropped and flagged. a beat with last_item closes the set and raises busy.
// output: one result beat, result_valid high for a single cycle, carrying
// mean_value, std_deviation, sample_count and status. the receiver cannot
// stall; busy falls in the same cycle the result is shown.
// after the closing beat: an empty or single set is answered from S_CLOSE
// without the divider. otherwise the shared one-bit-per-cycle divider runs
// twice (mean, variance), the store read port scans the n samples once,
// and the square root takes one bit per cycle.
// reset clears the count, the running sum and the overflow flag; the store
// itself is not cleared, only entries written in the open set are read.
module sample_mean_and_std_deviation_core import msd_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [SAMPLE_W-1:0]    sample_value,
	input  logic                          has_sample,
	input  logic                          last_item,
	output logic                          result_valid,
	output logic signed [SAMPLE_W-1:0]    mean_value,
	output logic        [SAMPLE_W-1:0]    std_deviation,
	output logic        [COUNT_OUT_W-1:0] sample_count,
	output logic        [1:0]             status
);

	localparam int AW    = $clog2(MAX_SAMPLES);
	localparam int CW    = $clog2(MAX_SAMPLES + 1);
	localparam int SW    = SAMPLE_W + CW;
	localparam int ACC_W = SQ_W + CW;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLOSE,
		S_MEAN_WAIT,
		S_SCAN,
		S_DRAIN,
		S_VAR_GO,
		S_VAR_WAIT,
		S_ROOT_WAIT
	} state_t;

	state_t                    state_q;
	logic [CW-1:0]             cnt_q;
	logic signed [SW-1:0]      sum_q;
	logic                      ovf_q;
	logic signed [SAMPLE_W-1:0] mean_q;
	logic [CW-1:0]             rd_idx_q;

	logic                      result_valid_q;
	logic signed [SAMPLE_W-1:0] mean_value_q;
	logic [SAMPLE_W-1:0]       std_deviation_q;
	logic [COUNT_OUT_W-1:0]    sample_count_q;
	logic [1:0]                status_q;

	logic                      accept;
	logic                      store_ok;
	logic [SW-1:0]             sum_mag;
	logic                      div_go;
	logic [ACC_W-1:0]          div_dvd;
	logic [CW-1:0]             div_dvs;
	logic                      div_done;
	logic [ACC_W-1:0]          div_q;
	logic                      sqrt_go;
	logic                      sqrt_done;
	logic [ROOT_W-1:0]         sqrt_root;
	logic [SAMPLE_W-1:0]       mean_nx;
	logic [SAMPLE_W-1:0]       rdata;

	logic                      vld_s1;
	logic                      vld_s2;
	logic [SQ_W-1:0]           prod_s2;
	logic [ACC_W-1:0]          acc_q;
	logic signed [DEV_W-1:0]   dev;
	logic signed [SQ_W-1:0]    dev_sq;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign store_ok = has_sample && (cnt_q < CW'(MAX_SAMPLES));
	assign sum_mag  = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);

	assign div_go  = ((state_q == S_CLOSE) && (cnt_q > CW'(1))) || (state_q == S_VAR_GO);
	assign div_dvd = (state_q == S_CLOSE) ? ACC_W'(sum_mag) : acc_q;
	assign div_dvs = (state_q == S_CLOSE) ? cnt_q : cnt_q - 1'b1;
	assign sqrt_go = (state_q == S_VAR_WAIT) && div_done;
	assign mean_nx = sum_q[SW-1] ? (~div_q[SAMPLE_W-1:0] + 1'b1) : div_q[SAMPLE_W-1:0];

	msd_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(MAX_SAMPLES)
	) u_store (
		.clk  (clk),
		.we   (accept && store_ok),
		.waddr(cnt_q[AW-1:0]),
		.wdata(sample_value),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(rdata)
	);

	msd_div #(
		.DVD_W(ACC_W),
		.DVS_W(CW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (div_go),
		.dividend(div_dvd),
		.divisor (div_dvs),
		.done    (div_done),
		.quotient(div_q)
	);

	msd_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (sqrt_go),
		.radicand(div_q[VAR_W-1:0]),
		.done    (sqrt_done),
		.root    (sqrt_root)
	);

	// second pass: deviation squared, then accumulate
	assign dev    = {rdata[SAMPLE_W-1], rdata} - {mean_q[SAMPLE_W-1], mean_q};
	assign dev_sq = dev * dev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_SCAN);
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= SQ_W'(dev_sq);
		if (state_q == S_MEAN_WAIT) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			cnt_q           <= '0;
			sum_q           <= '0;
			ovf_q           <= 1'b0;
			mean_q          <= '0;
			rd_idx_q        <= '0;
			result_valid_q  <= 1'b0;
			mean_value_q    <= '0;
			std_deviation_q <= '0;
			sample_count_q  <= '0;
			status_q        <= ST_OK;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (store_ok) begin
							cnt_q <= cnt_q + 1'b1;
							sum_q <= sum_q + SW'(sample_value);
						end else if (has_sample) begin
							ovf_q <= 1'b1;
						end
						if (last_item) begin
							state_q <= S_CLOSE;
						end
					end
				end
				S_CLOSE: begin
					if (cnt_q == '0) begin
						result_valid_q  <= 1'b1;
						mean_value_q    <= '0;
						std_deviation_q <= '0;
						sample_count_q  <= '0;
						status_q        <= ST_EMPTY;
						state_q         <= S_IDLE;
					end else if (cnt_q == CW'(1)) begin
						result_valid_q  <= 1'b1;
						mean_value_q    <= sum_q[SAMPLE_W-1:0];
						std_deviation_q <= '0;
						sample_count_q  <= COUNT_OUT_W'(cnt_q);
						status_q        <= ST_SINGLE;
						cnt_q           <= '0;
						sum_q           <= '0;
						ovf_q           <= 1'b0;
						state_q         <= S_IDLE;
					end else begin
						state_q <= S_MEAN_WAIT;
					end
				end
				S_MEAN_WAIT: begin
					if (div_done) begin
						mean_q   <= mean_nx;
						rd_idx_q <= '0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					rd_idx_q <= rd_idx_q + 1'b1;
					if (rd_idx_q == cnt_q - 1'b1) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!vld_s1 && !vld_s2) begin
						state_q <= S_VAR_GO;
					end
				end
				S_VAR_GO: begin
					state_q <= S_VAR_WAIT;
				end
				S_VAR_WAIT: begin
					if (div_done) begin
						state_q <= S_ROOT_WAIT;
					end
				end
				S_ROOT_WAIT: begin
					if (sqrt_done) begin
						result_valid_q  <= 1'b1;
						mean_value_q    <= mean_q;
						std_deviation_q <= sqrt_root[ROOT_W-1] ? '1 : sqrt_root[SAMPLE_W-1:0];
						sample_count_q  <= COUNT_OUT_W'(cnt_q);
						status_q        <= ovf_q ? ST_OVERFLOW : ST_OK;
						cnt_q           <= '0;
						sum_q           <= '0;
						ovf_q           <= 1'b0;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid  = result_valid_q;
	assign mean_value    = mean_value_q;
	assign std_deviation = std_deviation_q;
	assign sample_count  = sample_count_q;
	assign status        = status_q;

endmodule

### rtl/core/msd_ram.sv
module msd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/msd_div.sv
module msd_div import msd_pkg::*; #(
	parameter int DVD_W = SQ_W + COUNT_OUT_W,
	parameter int DVS_W = COUNT_OUT_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dq_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DVS_W:0]   rem_sh;
	logic [DVS_W:0]   rem_sub;
	logic             q_bit;

	assign rem_sh  = {rem_q, dq_q[DVD_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign q_bit   = (rem_sh >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dq_q  <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dq_q  <= {dq_q[DVD_W-2:0], q_bit};
			rem_q <= q_bit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

### rtl/core/msd_sqrt.sv
module msd_sqrt import msd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [VAR_W-1:0]  radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [VAR_W-1:0]  x_q;
	logic [ROOT_W:0]   rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;
	logic [ROOT_W+2:0] rem_sh;
	logic [ROOT_W+2:0] trial;
	logic [ROOT_W+2:0] rem_sub;
	logic              r_bit;

	assign rem_sh  = {rem_q, x_q[VAR_W-1:VAR_W-2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign rem_sub = rem_sh - trial;
	assign r_bit   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(ROOT_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			x_q    <= {x_q[VAR_W-3:0], 2'b00};
			rem_q  <= r_bit ? rem_sub[ROOT_W:0] : rem_sh[ROOT_W:0];
			root_q <= {root_q[ROOT_W-2:0], r_bit};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### rtl/core/msd_checker.sv
module msd_checker import msd_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   last_item,
	input logic                   result_valid,
	input logic [SAMPLE_W-1:0]    mean_value,
	input logic [SAMPLE_W-1:0]    std_deviation,
	input logic [COUNT_OUT_W-1:0] sample_count,
	input logic [1:0]             status
);

	// a closing beat always locks the input side
	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_item |=> busy)
		else $error("closing beat did not raise busy");

	// result beat releases the input side
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result shown while busy");

	a_result_single_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result beats back to back");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_EMPTY) |->
			(sample_count == '0) && (mean_value == '0) && (std_deviation == '0))
		else $error("empty set result not zero");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_SINGLE) |->
			(sample_count == COUNT_OUT_W'(1)) && (std_deviation == '0))
		else $error("single sample result malformed");

endmodule

bind sample_mean_and_std_deviation_core msd_checker u_msd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.last_item    (last_item),
	.result_valid (result_valid),
	.mean_value   (mean_value),
	.std_deviation(std_deviation),
	.sample_count (sample_count),
	.status       (status)
);

### sim/tb.sv
module tb;
	import msd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 800000;
	localparam int RANDOM_BEATS = 450;
	localparam int DRAIN_CYCLES = 1200;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mean;
		logic [SAMPLE_W-1:0]        std;
		logic [COUNT_OUT_W-1:0]     count;
		logic [1:0]                 status;
	} stats_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		bit                         has;
		bit                         last;
		bit                         typed;
		stats_t                     want;
	} dir_row_t;

	localparam int DIR_ROWS = 21;

	// typed rows: empty set, single extremes, constant set, single via a closing beat
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{16'sd0, 1'b0, 1'b1, 1'b1, '{16'sd0, 16'd0, 11'd0, ST_EMPTY}},
		'{16'sh7fff, 1'b1, 1'b1, 1'b1, '{16'sh7fff, 16'd0, 11'd1, ST_SINGLE}},
		'{16'sh8000, 1'b1, 1'b1, 1'b1, '{16'sh8000, 16'd0, 11'd1, ST_SINGLE}},
		'{16'sd0, 1'b0, 1'b0, 1'b0, '0},
		'{16'sh1000, 1'b1, 1'b0, 1'b0, '0},
		'{16'sh7fff, 1'b0, 1'b0, 1'b0, '0},
		'{16'sh3000, 1'b1, 1'b1, 1'b0, '0},
		'{16'sh8000, 1'b1, 1'b0, 1'b0, '0},
		'{16'sh7fff, 1'b1, 1'b1, 1'b0, '0},
		'{-16'sd3, 1'b1, 1'b0, 1'b0, '0},
		'{-16'sd4, 1'b1, 1'b1, 1'b0, '0},
		'{16'sd5, 1'b1, 1'b0, 1'b0, '0},
		'{16'sd5, 1'b1, 1'b0, 1'b0, '0},
		'{16'sd5, 1'b1, 1'b1, 1'b1, '{16'sd5, 16'd0, 11'd3, ST_OK}},
		'{16'sd100, 1'b1, 1'b0, 1'b0, '0},
		'{-16'sd200, 1'b1, 1'b0, 1'b0, '0},
		'{-16'sd1, 1'b0, 1'b1, 1'b0, '0},
		'{16'sh0abc, 1'b1, 1'b0, 1'b0, '0},
		'{16'sh5555, 1'b0, 1'b1, 1'b1, '{16'sh0abc, 16'd0, 11'd1, ST_SINGLE}},
		'{-16'sd1, 1'b1, 1'b0, 1'b0, '0},
		'{16'sd0, 1'b1, 1'b1, 1'b0, '0}
	};

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	logic signed [SAMPLE_W-1:0]  sample_value = '0;
	logic                        has_sample = 1'b0;
	logic                        last_item = 1'b0;
	logic                        result_valid;
	logic signed [SAMPLE_W-1:0]  mean_value;
	logic [SAMPLE_W-1:0]         std_deviation;
	logic [COUNT_OUT_W-1:0]      sample_count;
	logic [1:0]                  status;

	sample_mean_and_std_deviation_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.sample_value (sample_value),
		.has_sample   (has_sample),
		.last_item    (last_item),
		.result_valid (result_valid),
		.mean_value   (mean_value),
		.std_deviation(std_deviation),
		.sample_count (sample_count),
		.status       (status)
	);

	// predictor state for the open set
	logic signed [SAMPLE_W-1:0] open_samples [MAX_SAMPLES_DEF];
	longint open_sum = 0;
	int     open_count = 0;
	bit     open_dropped = 1'b0;

	stats_t pending_stats [$];
	int     mismatches = 0;
	int     beats_sent = 0;
	int     sets_closed = 0;
	int     status_seen [4] = '{0, 0, 0, 0};
	int     cycles = 0;
	bit     no_idle = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned floor_root(input longint unsigned x);
		longint unsigned r;
		longint unsigned trial;
		r = 0;
		for (int i = 31; i >= 0; i--) begin
			trial = r | (64'd1 << i);
			if (trial * trial <= x)
				r = trial;
		end
		return r;
	endfunction

	function automatic bit predict_stats(input logic signed [SAMPLE_W-1:0] v, input bit has,
			input bit last, output stats_t r);
		longint          avg;
		longint          dev;
		longint unsigned sq_sum;
		longint unsigned spread;
		longint unsigned root;
		r = '0;
		if (has) begin
			if (open_count < MAX_SAMPLES_DEF) begin
				open_samples[open_count] = v;
				open_sum += v;
				open_count++;
			end else begin
				open_dropped = 1'b1;
			end
		end
		if (!last)
			return 1'b0;
		r.count = open_count[COUNT_OUT_W-1:0];
		if (open_count == 0) begin
			r.status = ST_EMPTY;
		end else if (open_count == 1) begin
			r.mean = open_samples[0];
			r.status = ST_SINGLE;
		end else begin
			avg = open_sum / open_count;
			sq_sum = 0;
			for (int i = 0; i < open_count; i++) begin
				dev = longint'(open_samples[i]) - avg;
				sq_sum += longint'(dev * dev);
			end
			spread = sq_sum / longint'(open_count - 1);
			root = floor_root(spread);
			r.mean = avg[SAMPLE_W-1:0];
			r.std = (root > 65535) ? 16'hffff : root[SAMPLE_W-1:0];
			r.status = open_dropped ? ST_OVERFLOW : ST_OK;
		end
		open_sum = 0;
		open_count = 0;
		open_dropped = 1'b0;
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_value(input int shape,
			input logic signed [SAMPLE_W-1:0] center);
		case (shape)
			0: return SAMPLE_W'($urandom);
			1: return center + SAMPLE_W'($urandom_range(0, 64)) - 16'sd32;
			2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return center;
		endcase
	endfunction

	task automatic send_item(input logic signed [SAMPLE_W-1:0] v, input bit has, input bit last,
			input bit typed, input stats_t want);
		int     gap;
		stats_t r;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		sample_value <= v;
		has_sample <= has;
		last_item <= last;
		do @(posedge clk); while (busy !== 1'b0);
		if (predict_stats(v, has, last, r)) begin
			pending_stats.push_back(typed ? want : r);
			sets_closed++;
		end
		if (has || last)
			beats_sent++;
	endtask

	// one set of n samples with random noise beats, closed with or without a sample
	task automatic run_set(input int n, input int shape);
		logic signed [SAMPLE_W-1:0] center;
		bit                         bare_close;
		int                         counted;
		center = SAMPLE_W'($urandom);
		bare_close = (n == 0) || ($urandom_range(0, 3) == 0);
		no_idle = ($urandom_range(0, 9) < 3);
		counted = 0;
		while (counted < n) begin
			if ($urandom_range(0, 99) < 8) begin
				send_item(SAMPLE_W'($urandom), 1'b0, 1'b0, 1'b0, '0);
			end else begin
				counted++;
				send_item(pick_value(shape, center), 1'b1,
					!bare_close && counted == n, 1'b0, '0);
			end
		end
		if (bare_close)
			send_item(SAMPLE_W'($urandom), 1'b0, 1'b1, 1'b0, '0);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1) begin
			if (pending_stats.size() == 0) begin
				$error("result beat with nothing expected: mean %0d std %0d count %0d status %0d",
					mean_value, std_deviation, sample_count, status);
				mismatches++;
			end else begin
				stats_t e;
				e = pending_stats.pop_front();
				if (mean_value !== e.mean) begin
					$error("mean_value expected %0d actual %0d", e.mean, mean_value);
					mismatches++;
				end
				if (std_deviation !== e.std) begin
					$error("std_deviation expected %0d actual %0d", e.std, std_deviation);
					mismatches++;
				end
				if (sample_count !== e.count) begin
					$error("sample_count expected %0d actual %0d", e.count, sample_count);
					mismatches++;
				end
				if (status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, status);
					mismatches++;
				end
				status_seen[e.status]++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_stats.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int set_size;
		int r;
		int rand_beats;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			send_item(DIR_TABLE[i].value, DIR_TABLE[i].has, DIR_TABLE[i].last,
				DIR_TABLE[i].typed, DIR_TABLE[i].want);

		// a completely full store, then one that overflows and drops on the closing beat
		no_idle = 1'b0;
		for (int i = 0; i < MAX_SAMPLES_DEF; i++)
			send_item(SAMPLE_W'($urandom), 1'b1, i == MAX_SAMPLES_DEF - 1, 1'b0, '0);
		set_size = MAX_SAMPLES_DEF + $urandom_range(1, 6);
		for (int i = 0; i < set_size; i++)
			send_item(pick_value(1, 16'sh0400), 1'b1, i == set_size - 1, 1'b0, '0);

		rand_beats = beats_sent;
		while (beats_sent - rand_beats < RANDOM_BEATS) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				set_size = 0;
			else if (r < 16)
				set_size = 1;
			else if (r < 80)
				set_size = $urandom_range(2, 12);
			else
				set_size = $urandom_range(13, 60);
			run_set(set_size, $urandom_range(0, 3));
		end

		start <= 1'b0;
		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d sets closed over %0d beats, including a full store and an overflowing one",
			sets_closed, beats_sent);
		$display("results by status: ok %0d, single %0d, empty %0d, overflow %0d",
			status_seen[ST_OK], status_seen[ST_SINGLE], status_seen[ST_EMPTY],
			status_seen[ST_OVERFLOW]);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
